FILE: design/assert_macros.svh
// Assertion helpers for the profiler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PFL_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("profiler assertion failed");
`define PFL_ASSERT_RST(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("profiler assertion failed");
`else
`define PFL_ASSERT(lbl, ck, rn, prop)
`define PFL_ASSERT_RST(lbl, ck, prop)
`endif
`endif

FILE: design/pfl_pkg.sv
package pfl_pkg;
  localparam int DEPTH  = 512;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int TIME_W = 48;

  typedef enum logic [2:0] {
    OP_ENTER = 3'd0,
    OP_EXIT  = 3'd1,
    OP_START = 3'd2,
    OP_STOP  = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_DISABLED = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_GATHER,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [31:0]       func;
    logic [31:0]       calls;
    logic [31:0]       runtime;
    logic [TIME_W-1:0] since;
    logic              open;
  } entry_t;
endpackage

FILE: design/function_entry_exit_profiler.sv
// Each input word passes lookup, gather and update in turn; update stalls while an untaken
// result word waits in the output register. A new word is taken only in idle, after update.
// A result word waits in the output register while the next word is taken.
// Reset (rst_n low, synchronous) clears the address and open flag of every slot, the used
// count and the start time, and disables the profiler.
module function_entry_exit_profiler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // func_addr[31:0], timestamp[79:32], read_index[88:80]
  input  logic [2:0]   in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [167:0] out_tdata,  // slot, entry_func, entry_calls, entry_time,
                                   // frames_used, elapsed
  output logic [1:0]   out_tuser   // status
);
  import pfl_pkg::*;
  `include "assert_macros.svh"

  state_t            state_r, state_nxt;
  op_t               op_r;
  logic [31:0]       addr_r;
  logic [TIME_W-1:0] ts_r;
  logic [IDX_W-1:0]  ridx_r;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic              run_r, run_nxt;

  logic [DEPTH-1:0]  hit;
  entry_t            cell_e [DEPTH];
  logic [DEPTH-1:0]  sel;
  logic [DEPTH-1:0]  sel_r;
  entry_t            g_e, g_r;
  logic [IDX_W-1:0]  g_idx, g_idx_r;
  logic              any_hit, claim, any_hit_r, claim_r;
  logic [DEPTH-1:0]  wr_en;
  entry_t            wr_e;
  logic              clr;

  logic              out_v_r, out_v_nxt;
  logic [167:0]      out_d_r, out_d_nxt;
  logic [1:0]        out_u_r, out_u_nxt;
  logic              exec_go;

  entry_t            base;
  logic [31:0]       o_func, o_calls, o_time;
  logic [IDX_W-1:0]  o_slot;
  logic [TIME_W-1:0] o_el;
  status_t           o_st;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cells
    pfl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clr      (clr),
      .wr_en    (wr_en[i]),
      .wr_entry (wr_e),
      .cmp_addr (addr_r),
      .hit      (hit[i]),
      .entry    (cell_e[i])
    );
  end

  always_comb begin
    any_hit = |hit;
    claim   = !any_hit && (used_r < CNT_W'(DEPTH));
    g_e     = '0;
    g_idx   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (op_r == OP_READ) begin
        sel[i] = (IDX_W'(i) == ridx_r) && (CNT_W'(i) < used_r);
      end else if (any_hit) begin
        sel[i] = hit[i];
      end else begin
        sel[i] = claim && (CNT_W'(i) == used_r);
      end
      g_e   = g_e | (sel[i] ? cell_e[i] : '0);
      g_idx = g_idx | (sel[i] ? IDX_W'(i) : '0);
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign exec_go   = (state_r == S_EXEC) && (!out_v_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      start_r <= '0;
      run_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      start_r <= start_nxt;
      run_r   <= run_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= op_t'(in_tuser);
      addr_r <= in_tdata[31:0];
      ts_r   <= in_tdata[79:32];
      ridx_r <= in_tdata[88:80];
    end
    if (state_r == S_GATHER) begin
      sel_r     <= sel;
      g_r       <= g_e;
      g_idx_r   <= g_idx;
      any_hit_r <= any_hit;
      claim_r   <= claim;
    end
    if (exec_go) begin
      out_d_r <= out_d_nxt;
      out_u_r <= out_u_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    start_nxt = start_r;
    run_nxt   = run_r;
    out_v_nxt = out_v_r && !out_tready;
    clr       = 1'b0;
    wr_en     = '0;
    o_st      = ST_OK;
    o_slot    = '0;
    o_func    = '0;
    o_calls   = '0;
    o_time    = '0;
    o_el      = '0;
    base      = claim_r ? '0 : g_r;
    wr_e      = base;
    wr_e.func = addr_r;
    if (base.open) begin
      wr_e.runtime = base.runtime + 32'(ts_r - base.since);
    end
    if (op_r == OP_ENTER) begin
      wr_e.since = ts_r;
      wr_e.open  = 1'b1;
      wr_e.calls = base.calls + 32'd1;
    end else begin
      wr_e.since = '0;
      wr_e.open  = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_GATHER;
      end
      S_GATHER: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
          out_v_nxt = 1'b1;
          case (op_r)
            OP_ENTER, OP_EXIT: begin
              if (!run_r) begin
                o_st = ST_DISABLED;
              end else if (addr_r != '0) begin
                if (!any_hit_r && !claim_r) begin
                  o_st = ST_FULL;
                end else begin
                  wr_en    = sel_r;
                  used_nxt = used_r + CNT_W'(claim_r);
                  o_slot   = g_idx_r;
                  o_func   = wr_e.func;
                  o_calls  = wr_e.calls;
                  o_time   = wr_e.runtime;
                end
              end
            end
            OP_START: begin
              clr       = 1'b1;
              used_nxt  = '0;
              start_nxt = ts_r;
              run_nxt   = 1'b1;
            end
            OP_STOP: begin
              run_nxt = 1'b0;
            end
            OP_READ: begin
              o_slot = ridx_r;
              o_el   = ts_r - start_r;
              if ({1'b0, ridx_r} < used_r) begin
                o_func  = g_r.func;
                o_calls = g_r.calls;
                o_time  = g_r.runtime;
              end else begin
                o_st = ST_UNUSED;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_u_nxt = o_st;
    out_d_nxt = {5'd0, o_el, used_nxt, o_time, o_calls, o_func, o_slot};
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_u_r;

  `PFL_ASSERT(a_wr_onehot, clk, rst_n, $onehot0(wr_en))
  `PFL_ASSERT(a_used_max, clk, rst_n, used_r <= CNT_W'(DEPTH))
  `PFL_ASSERT(a_exec_out, clk, rst_n, exec_go |=> out_tvalid)
  `PFL_ASSERT(a_wr_running, clk, rst_n, (wr_en != '0) |-> run_r)
endmodule

FILE: design/pfl_cell.sv
module pfl_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clr,
  input  logic            wr_en,
  input  pfl_pkg::entry_t wr_entry,
  input  logic [31:0]     cmp_addr,
  output logic            hit,
  output pfl_pkg::entry_t entry
);
  import pfl_pkg::*;

  entry_t entry_r;
  logic   hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      entry_r.func <= '0;
      entry_r.open <= 1'b0;
    end else if (wr_en) begin
      entry_r.func <= wr_entry.func;
      entry_r.open <= wr_entry.open;
    end
    if (wr_en) begin
      entry_r.calls   <= wr_entry.calls;
      entry_r.runtime <= wr_entry.runtime;
      entry_r.since   <= wr_entry.since;
    end
    hit_r <= (entry_r.func == cmp_addr) && (cmp_addr != '0);
  end

  assign hit   = hit_r;
  assign entry = entry_r;
endmodule
